// File: rtl/wcts_pkg.sv
package wcts_pkg;

    // Fixed field widths of the request and response
    localparam int FIELD_BITS  = 16;
    localparam int HANDLE_BITS = 8;
    localparam int COUNT_BITS  = 5;
    localparam int STATUS_BITS = 3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_FULL     = 3'd2,
        ST_SELECTED = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOHIT    = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SELECT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [0:0]             opcode;
        logic [HANDLE_BITS-1:0] channel_handle;
        logic [FIELD_BITS-1:0]  owner_tag;
        logic [FIELD_BITS-1:0]  weight;
        logic [FIELD_BITS-1:0]  draw;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [HANDLE_BITS-1:0] chosen_handle;
        logic [COUNT_BITS-1:0]  entry_count;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    ins_start;
        logic    sel_start;
        logic    shift;
        logic    put;
        logic    sel_step;
        logic    finish;
        status_t code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_insert;
        logic mismatch;
        logic full;
        logic empty;
        logic greater;
        logic at_first;
        logic hit;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/wcts_ram.sv
module wcts_ram #(
    parameter int DATA_BITS = 24,
    parameter int DEPTH     = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/wcts_ctrl.sv
module wcts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  wcts_pkg::dp_stat_t    stat,
    output wcts_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_PUT  = 5'b00100,
        S_SEL  = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    wcts_pkg::status_t code_reg, code_next;

    // Hold state and pending reject code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= wcts_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // Sequence each request
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = wcts_pkg::ST_INSERTED;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.is_insert)
                    begin
                        if (stat.mismatch)
                        begin
                            code_next  = wcts_pkg::ST_MISMATCH;
                            state_next = S_RESP;
                        end
                        else if (stat.full)
                        begin
                            code_next  = wcts_pkg::ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = stat.empty ? S_PUT : S_INS;
                        end
                    end
                    else if (stat.empty)
                    begin
                        code_next  = wcts_pkg::ST_EMPTY;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.sel_start = 1'b1;
                        state_next    = S_SEL;
                    end
                end
            end
            S_INS:
            begin
                // Move smaller entries up one slot, or drop the new one in
                if (stat.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = stat.at_first ? S_PUT : S_INS;
                end
                else if (stat.out_free)
                begin
                    cmd.put    = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.code   = wcts_pkg::ST_INSERTED;
                    state_next = S_IDLE;
                end
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put    = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.code   = wcts_pkg::ST_INSERTED;
                    state_next = S_IDLE;
                end
            end
            S_SEL:
            begin
                // Accumulate weights until the running sum passes the draw or the last entry is reached
                if (stat.hit || stat.last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = stat.hit ? wcts_pkg::ST_SELECTED : wcts_pkg::ST_NOHIT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.sel_step = 1'b1;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = code_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wcts_dp.sv
module wcts_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wcts_pkg::req_t        req,
    input  wcts_pkg::ctrl_cmd_t   cmd,
    output wcts_pkg::dp_stat_t    stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output wcts_pkg::rsp_t        rsp
);

    localparam int SW   = (WEIGHT_BITS < wcts_pkg::FIELD_BITS) ?
                          WEIGHT_BITS : wcts_pkg::FIELD_BITS;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SUMW = SW + CW;
    localparam int HB   = wcts_pkg::HANDLE_BITS;
    localparam int DW   = HB + SW;

    logic [HB-1:0]   handle_reg;
    logic [SW-1:0]   weight_reg;
    logic [SW-1:0]   draw_reg;
    logic            owner_known_reg;
    logic [wcts_pkg::FIELD_BITS-1:0] owner_reg;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic            rsp_valid_reg, rsp_valid_next;
    wcts_pkg::rsp_t  rsp_reg, rsp_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;
    logic            rd_en;
    logic [CW-1:0]   rd_idx;
    logic [DW-1:0]   rd_data;
    logic [HB-1:0]   rd_handle;
    logic [SW-1:0]   rd_weight;
    logic [SUMW-1:0] sum_add;
    logic [CW-1:0]   idx_inc;
    logic            out_free;

    assign rd_handle = rd_data[DW-1:SW];
    assign rd_weight = rd_data[SW-1:0];
    assign sum_add   = sum_reg + SUMW'(rd_weight);
    assign idx_inc   = idx_reg + CW'(1);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Status toward the controller
    always_comb
    begin
        stat           = '0;
        stat.is_insert = (req.opcode == wcts_pkg::OP_INSERT);
        stat.mismatch  = owner_known_reg && (req.owner_tag != owner_reg);
        stat.full      = (fill_reg == CW'(TABLE_DEPTH));
        stat.empty     = (fill_reg == '0);
        stat.greater   = (weight_reg > rd_weight);
        stat.at_first  = (idx_reg == CW'(1));
        stat.hit       = (SUMW'(draw_reg) < sum_add);
        stat.last      = (idx_inc == fill_reg);
        stat.out_free  = out_free;
    end

    // Table port steering
    always_comb
    begin
        wr_en   = cmd.shift || cmd.put;
        wr_addr = idx_reg[AW-1:0];
        wr_data = cmd.shift ? rd_data : {handle_reg, weight_reg};
        rd_en   = 1'b0;
        rd_idx  = '0;
        if (cmd.ins_start)
        begin
            rd_en  = (fill_reg != '0);
            rd_idx = fill_reg - CW'(1);
        end
        else if (cmd.shift)
        begin
            rd_en  = (idx_reg >= CW'(2));
            rd_idx = idx_reg - CW'(2);
        end
        else if (cmd.sel_start)
        begin
            rd_en  = 1'b1;
            rd_idx = '0;
        end
        else if (cmd.sel_step)
        begin
            rd_en  = 1'b1;
            rd_idx = idx_inc;
        end
    end

    wcts_ram #(
        .DATA_BITS (DW),
        .DEPTH     (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // Scan index, running sum, fill count, result
    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (cmd.ins_start)
        begin
            idx_next = fill_reg;
        end
        if (cmd.sel_start)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        if (cmd.shift)
        begin
            idx_next = idx_reg - CW'(1);
        end
        if (cmd.sel_step)
        begin
            idx_next = idx_inc;
            sum_next = sum_add;
        end
        if (cmd.put)
        begin
            fill_next = fill_reg + CW'(1);
        end
        if (cmd.finish)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = cmd.code;
            rsp_next.chosen_handle = (cmd.code == wcts_pkg::ST_SELECTED) ? rd_handle : '0;
            rsp_next.entry_count  = wcts_pkg::COUNT_BITS'(fill_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            owner_known_reg <= 1'b0;
            owner_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.load && stat.is_insert && !owner_known_reg)
            begin
                owner_known_reg <= 1'b1;
                owner_reg       <= req.owner_tag;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        rsp_reg <= rsp_next;
        if (cmd.load)
        begin
            handle_reg <= req.channel_handle;
            weight_reg <= req.weight[SW-1:0];
            draw_reg   <= req.draw[SW-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/weighted_channel_table_select_unit.sv
// One request at a time: the next request is accepted the cycle after a response is loaded.
// An insert moves each table entry lighter than the new one up one slot through the table
// memory, then puts the new entry in the freed slot.
// A select reads and sums entries in order until the running sum passes the draw or the last entry is reached.
// Rejects (owner mismatch, full, empty) go to the S_RESP state and respond from there.
// Reset clears the fill count, owner tag and handshake state; the table is left as is.
module weighted_channel_table_select_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  wcts_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output wcts_pkg::rsp_t  rsp
);

    wcts_pkg::ctrl_cmd_t cmd;
    wcts_pkg::dp_stat_t  stat;

    wcts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wcts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: dv/weighted_channel_table_select_unit_test.sv
`timescale 1ns / 1ps

module weighted_channel_table_select_unit_test;

    localparam int DEPTH        = 16;
    localparam int WBITS        = 16;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 400;

    // One row of the directed plan: request, whether a typed answer is given, the answer
    typedef struct packed {
        wcts_pkg::req_t item;
        logic           typed;
        wcts_pkg::rsp_t want;
    } plan_row_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    wcts_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    wcts_pkg::rsp_t rsp;

    // Mirror of the channel table, kept in sorted order
    logic [wcts_pkg::HANDLE_BITS-1:0] mirror_handle [DEPTH];
    logic [WBITS-1:0]                 mirror_weight [DEPTH];
    int unsigned                      mirror_fill;
    bit                               owner_set;
    logic [wcts_pkg::FIELD_BITS-1:0]  owner_held;

    wcts_pkg::rsp_t owed_rsp [$];
    int unsigned    errors;
    int unsigned    status_seen [8];
    int unsigned    requests_sent;
    int unsigned    burst_left;

    weighted_channel_table_select_unit #(
        .TABLE_DEPTH (DEPTH),
        .WEIGHT_BITS (WBITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Apply one request to the mirror table and return the response it earns
    function automatic wcts_pkg::rsp_t predict_table_op(input wcts_pkg::req_t r);
        wcts_pkg::rsp_t res;
        int unsigned    pos;
        int unsigned    i;
        bit             found;
        logic [31:0]    running;
        res = '0;
        if (r.opcode == wcts_pkg::OP_INSERT)
        begin
            if (!owner_set)
            begin
                owner_set  = 1'b1;
                owner_held = r.owner_tag;
            end
            if (r.owner_tag != owner_held)
                res.status = wcts_pkg::ST_MISMATCH;
            else if (mirror_fill >= DEPTH)
                res.status = wcts_pkg::ST_FULL;
            else
            begin
                // place ahead of the first strictly lighter entry
                pos   = mirror_fill;
                found = 1'b0;
                for (i = 0; i < mirror_fill; i++)
                begin
                    if (!found && r.weight > mirror_weight[i])
                    begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (i = mirror_fill; i > pos; i--)
                begin
                    mirror_handle[i] = mirror_handle[i-1];
                    mirror_weight[i] = mirror_weight[i-1];
                end
                mirror_handle[pos] = r.channel_handle;
                mirror_weight[pos] = r.weight;
                mirror_fill++;
                res.status = wcts_pkg::ST_INSERTED;
            end
        end
        else if (mirror_fill == 0)
            res.status = wcts_pkg::ST_EMPTY;
        else
        begin
            // walk the wheel until the running sum passes the draw
            res.status = wcts_pkg::ST_NOHIT;
            running    = '0;
            found      = 1'b0;
            for (i = 0; i < mirror_fill; i++)
            begin
                running += 32'(mirror_weight[i]);
                if (!found && 32'(r.draw) < running)
                begin
                    found             = 1'b1;
                    res.status        = wcts_pkg::ST_SELECTED;
                    res.chosen_handle = mirror_handle[i];
                end
            end
        end
        res.entry_count = mirror_fill[wcts_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    function automatic wcts_pkg::req_t insert_req(input logic [7:0] h, input logic [15:0] tag,
                                                  input logic [15:0] w);
        wcts_pkg::req_t r;
        logic [63:0]    noise;
        noise            = {$urandom, $urandom};
        r                = noise[$bits(wcts_pkg::req_t)-1:0];
        r.opcode         = wcts_pkg::OP_INSERT;
        r.channel_handle = h;
        r.owner_tag      = tag;
        r.weight         = w;
        return r;
    endfunction

    function automatic wcts_pkg::req_t select_req(input logic [15:0] d);
        wcts_pkg::req_t r;
        logic [63:0]    noise;
        noise    = {$urandom, $urandom};
        r        = noise[$bits(wcts_pkg::req_t)-1:0];
        r.opcode = wcts_pkg::OP_SELECT;
        r.draw   = d;
        return r;
    endfunction

    function automatic plan_row_t row(input wcts_pkg::req_t r, input logic typed,
                                      input wcts_pkg::status_t st,
                                      input logic [7:0] h, input logic [4:0] n);
        plan_row_t p;
        p.item               = r;
        p.typed              = typed;
        p.want.status        = st;
        p.want.chosen_handle = h;
        p.want.entry_count   = n;
        return p;
    endfunction

    // Offer one request, first sitting idle for a random gap, which may be none, when the current burst is used up
    task automatic offer_request(input wcts_pkg::req_t r, input logic typed,
                                 input wcts_pkg::rsp_t want);
        wcts_pkg::rsp_t predicted;
        int unsigned    gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_table_op(r);
        owed_rsp  = {owed_rsp, (typed ? want : predicted)};
        requests_sent++;
    endtask

    // Check each accepted response against the oldest owed one
    always @(posedge clk)
    begin : check_rsp
        wcts_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            status_seen[rsp.status]++;
            if (owed_rsp.size() == 0)
            begin
                $error("response with none owed: status %0d handle %02h count %0d",
                       rsp.status, rsp.chosen_handle, rsp.entry_count);
                errors++;
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.chosen_handle !== want.chosen_handle)
                begin
                    $error("chosen_handle: expected %02h, actual %02h",
                           want.chosen_handle, rsp.chosen_handle);
                    errors++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, rsp.entry_count);
                    errors++;
                end
            end
        end
    end

    // Stall the response side on its own pattern, with one long hold-off
    initial
    begin : drive_rsp_ready
        int unsigned mode;
        int unsigned len;
        int unsigned cycles;
        bit          held;
        rsp_ready = 1'b0;
        cycles    = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            repeat (len)
            begin
                @(posedge clk);
                cycles++;
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= (cycles % 3 == 0);
                endcase
            end
            if (!held && cycles > 3000)
            begin
                // hold off long enough for the block to back up into its input
                held = 1'b1;
                @(posedge clk);
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // Directed plan, then random traffic, then drain
    initial
    begin : stimulus
        plan_row_t      plan [$];
        wcts_pkg::req_t r;
        int unsigned    kind;
        int unsigned    total;
        int unsigned    i;
        logic [15:0]    tag;
        logic [15:0]    w;
        logic [15:0]    d;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        errors        = 0;
        requests_sent = 0;
        burst_left    = 0;
        mirror_fill   = 0;
        owner_set     = 1'b0;
        owner_held    = '0;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        plan = {plan, row(select_req(16'h0000), 1'b1,
                          wcts_pkg::ST_EMPTY, 8'h00, 5'd0)};
        plan = {plan, row(insert_req(8'h5A, 16'hABCD, 16'h0010), 1'b1,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd1)};
        plan = {plan, row(select_req(16'h0010), 1'b1,
                          wcts_pkg::ST_NOHIT, 8'h00, 5'd1)};
        plan = {plan, row(select_req(16'hFFFF), 1'b1,
                          wcts_pkg::ST_NOHIT, 8'h00, 5'd1)};
        plan = {plan, row(select_req(16'h000F), 1'b1,
                          wcts_pkg::ST_SELECTED, 8'h5A, 5'd1)};
        plan = {plan, row(insert_req(8'hA5, 16'h5432, 16'hFFFF), 1'b1,
                          wcts_pkg::ST_MISMATCH, 8'h00, 5'd1)};
        plan = {plan, row(insert_req(8'hFF, 16'hABCD, 16'h0000), 1'b1,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd2)};
        // a zero weight never raises the sum, so it cannot be picked
        plan = {plan, row(select_req(16'h0010), 1'b1,
                          wcts_pkg::ST_NOHIT, 8'h00, 5'd2)};
        plan = {plan, row(insert_req(8'h00, 16'hABCD, 16'hFFFF), 1'b1,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd3)};
        plan = {plan, row(insert_req(8'h11, 16'hABCD, 16'h8000), 1'b1,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd4)};
        plan = {plan, row(insert_req(8'h22, 16'hABCD, 16'h8000), 1'b1,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd5)};
        plan = {plan, row(select_req(16'h0000), 1'b1,
                          wcts_pkg::ST_SELECTED, 8'h00, 5'd5)};
        plan = {plan, row(select_req(16'hFFFF), 1'b0,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd0)};
        plan = {plan, row(select_req(16'h8000), 1'b0,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd0)};
        plan = {plan, row(insert_req(8'h33, 16'hABCD, 16'h0010), 1'b0,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd0)};
        plan = {plan, row(insert_req(8'hC3, 16'h0000, 16'h1234), 1'b1,
                          wcts_pkg::ST_MISMATCH, 8'h00, 5'd6)};
        plan = {plan, row(select_req(16'($urandom)), 1'b0,
                          wcts_pkg::ST_INSERTED, 8'h00, 5'd0)};

        foreach (plan[k])
            offer_request(plan[k].item, plan[k].typed, plan[k].want);

        // random mix: inserts (some foreign-tagged or past full) and selects with draws up to and past the total
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                tag = (kind < 5) ? 16'($urandom) : owner_held;
                case ($urandom_range(0, 3))
                    0: w = 16'($urandom);
                    1: w = 16'($urandom_range(0, 16'h0FFF));
                    2: w = mirror_fill != 0 ?
                           mirror_weight[$urandom_range(0, mirror_fill - 1)] : 16'h0100;
                    default: w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                endcase
                r = insert_req(8'($urandom), tag, w);
            end
            else
            begin
                total = 0;
                for (int j = 0; j < mirror_fill; j++)
                    total += mirror_weight[j];
                if (total > 16'hFFFF)
                    total = 16'hFFFF;
                case ($urandom_range(0, 2))
                    0: d = 16'($urandom);
                    1: d = 16'($urandom_range(0, total));
                    default: d = 16'(total) - 16'($urandom_range(0, 1));
                endcase
                r = select_req(d);
            end
            offer_request(r, 1'b0, '0);
        end

        // drop valid and drain what is still owed
        req_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d owner mismatch, %0d full, %0d selected,",
                 requests_sent, status_seen[wcts_pkg::ST_INSERTED],
                 status_seen[wcts_pkg::ST_MISMATCH], status_seen[wcts_pkg::ST_FULL],
                 status_seen[wcts_pkg::ST_SELECTED]);
        $display("%0d empty, %0d no hit; %0d entries held at the end",
                 status_seen[wcts_pkg::ST_EMPTY], status_seen[wcts_pkg::ST_NOHIT],
                 mirror_fill);
        if (errors == 0)
            $display("weighted_channel_table_select_unit: match");
        else
            $display("weighted_channel_table_select_unit: mismatch");
        $finish;
    end

    // Stop a run that hangs
    initial
    begin
        #4_000_000;
        $display("timeout with %0d responses still owed", owed_rsp.size());
        $display("weighted_channel_table_select_unit: mismatch");
        $finish;
    end

endmodule
